/* src/soundex_word_match_counter_core_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef SOUNDEX_WORD_MATCH_COUNTER_CORE_ASSERT_SVH
`define SOUNDEX_WORD_MATCH_COUNTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWMC_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWMC_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/swmc_pkg.sv */
`default_nettype none

package swmc_pkg;

	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 3;
	localparam int MATCH_W     = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int TARGET_REGS = 3;

	localparam logic [CHAR_W-1:0] WORD_SEP = 8'h20;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_LETTER = 2'd0,
		REG_DIGIT_ONE     = 2'd1,
		REG_DIGIT_TWO     = 2'd2,
		REG_DIGIT_THREE   = 2'd3
	} cfg_reg_t;

	function automatic logic is_letter(input char_t c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	// Soundex digit of a lowercase consonant; zero for anything else.
	function automatic digit_t soundex_digit(input char_t c);
		digit_t d;
		case (c)
			"b", "f", "p", "v":                     d = 3'd1;
			"c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
			"d", "t":                               d = 3'd3;
			"l":                                    d = 3'd4;
			"m", "n":                               d = 3'd5;
			"r":                                    d = 3'd6;
			default:                                d = 3'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

/* src/soundex_word_match_counter_core.sv */
// Counts, over a sentence streamed one byte per transfer, the words whose
// Soundex code equals the target code written to the configuration registers
// (0 target letter, 1 to 3 target digits). A space ends a word, other
// non-letters are dropped, and the first letter is compared case-sensitively.
// The transfer marked with tlast ends the sentence; one result transfer then
// carries the saturating match count, and the count restarts at zero. One
// byte is accepted every cycle except in the stall below: each byte passes an
// input register, one step of word-state update, and the output register,
// which takes a sentence's count from its last byte. The input side
// only stalls while a finished count waits to be taken and another sentence
// end is ready to follow it.
`default_nettype none

module soundex_word_match_counter_core #(
	parameter int COUNT_WIDTH = 16,
	parameter int CODE_DIGITS = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [swmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [swmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [swmc_pkg::CHAR_W-1:0]    s_axis_tdata,  // char_in
	input  wire logic                           s_axis_tlast,  // sentence_end
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [swmc_pkg::MATCH_W-1:0]        m_axis_tdata   // match_count
);
	import swmc_pkg::*;

	localparam int POS_W = $clog2(CODE_DIGITS + 1);

	char_t                  target_letter_q;
	digit_t                 target_digit_q [TARGET_REGS];
	digit_t                 target_c       [CODE_DIGITS];

	logic                   valid_s1;
	char_t                  char_s1;
	logic                   last_s1;

	char_t                  word_letter_q;
	logic                   word_started_q;
	digit_t                 word_digits_q  [CODE_DIGITS];
	logic [POS_W-1:0]       digit_pos_q;
	digit_t                 last_digit_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [MATCH_W-1:0]     match_count_q;
	logic                   out_valid_q;

	logic                   advance;
	logic                   letter;
	digit_t                 digit;
	logic                   take_first;
	logic                   take_digit;
	logic                   word_end;
	logic                   match;
	char_t                  letter_upd;
	logic                   started_upd;
	digit_t                 digits_upd     [CODE_DIGITS];
	logic [COUNT_WIDTH-1:0] count_inc;

	for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_target
		if (i < TARGET_REGS) begin : g_reg
			assign target_c[i] = target_digit_q[i];
		end else begin : g_pad
			assign target_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_letter_q <= '0;
			for (int i = 0; i < TARGET_REGS; i++) begin
				target_digit_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_LETTER: target_letter_q   <= cfg_data;
				REG_DIGIT_ONE:     target_digit_q[0] <= cfg_data[DIGIT_W-1:0];
				REG_DIGIT_TWO:     target_digit_q[1] <= cfg_data[DIGIT_W-1:0];
				REG_DIGIT_THREE:   target_digit_q[2] <= cfg_data[DIGIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		letter      = is_letter(char_s1);
		digit       = soundex_digit(char_s1);
		take_first  = letter && !word_started_q;
		take_digit  = letter && word_started_q &&
		              (digit_pos_q < POS_W'(CODE_DIGITS)) &&
		              (digit != '0) && (digit != last_digit_q);
		letter_upd  = take_first ? char_s1 : word_letter_q;
		started_upd = word_started_q || take_first;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			digits_upd[i] = (take_digit && digit_pos_q == POS_W'(i)) ? digit
			                                                        : word_digits_q[i];
		end
		word_end = (char_s1 == WORD_SEP) || last_s1;
		match    = word_end && started_upd && (letter_upd == target_letter_q);
		for (int i = 0; i < CODE_DIGITS; i++) begin
			match = match && (digits_upd[i] == target_c[i]);
		end
		count_inc = (match && !(&count_q)) ? count_q + 1'b1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_letter_q  <= '0;
			word_started_q <= 1'b0;
			digit_pos_q    <= '0;
			last_digit_q   <= '0;
			count_q        <= '0;
			for (int i = 0; i < CODE_DIGITS; i++) begin
				word_digits_q[i] <= '0;
			end
		end else if (advance) begin
			if (word_end) begin
				word_letter_q  <= '0;
				word_started_q <= 1'b0;
				digit_pos_q    <= '0;
				last_digit_q   <= '0;
				for (int i = 0; i < CODE_DIGITS; i++) begin
					word_digits_q[i] <= '0;
				end
			end else begin
				word_letter_q  <= letter_upd;
				word_started_q <= started_upd;
				word_digits_q  <= digits_upd;
				if (take_digit) begin
					digit_pos_q  <= POS_W'(digit_pos_q + 1'b1);
					last_digit_q <= digit;
				end
			end
			count_q <= last_s1 ? '0 : count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			match_count_q <= MATCH_W'(count_inc);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = match_count_q;

endmodule

`default_nettype wire

/* src/swmc_checker.sv */
`default_nettype none

`include "soundex_word_match_counter_core_assert.svh"

module swmc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             s_axis_tlast,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [swmc_pkg::MATCH_W-1:0]     m_axis_tdata
);
	import swmc_pkg::*;

	// With no count waiting on the output, the input side never stalls.
	`SWMC_ASSERT_SAME(a_ready_when_out_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

	// A byte that does not end a sentence never blocks the next transfer.
	`SWMC_ASSERT_NEXT(a_ready_after_inner_byte, clk, arst_n,
		s_axis_tvalid && s_axis_tready && !s_axis_tlast, s_axis_tready)

	// A stalled result stays offered.
	`SWMC_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid)

	// A stalled result keeps its count.
	`SWMC_ASSERT_NEXT(a_out_data_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata))

endmodule

bind soundex_word_match_counter_core swmc_checker u_swmc_checker (.*);

`default_nettype wire

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import swmc_pkg::*;

	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_reg_t           reg_idx;
		char_t              value;
		logic               last;
		logic               typed;
		logic [MATCH_W-1:0] count;
	} script_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [MATCH_W-1:0]     m_axis_tdata;

	soundex_word_match_counter_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	script_row_t script [0:23] = '{
		'{ROW_BYTE, REG_TARGET_LETTER, 8'h00, 1'b1, 1'b1, 16'd0},
		'{ROW_REG,  REG_TARGET_LETTER, "R",   1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIGIT_ONE,     8'h01, 1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIGIT_TWO,     8'h06, 1'b0, 1'b0, 16'd0},
		'{ROW_REG,  REG_DIGIT_THREE,   8'hFB, 1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "R",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "b",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "a",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "b",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "r",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "t",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, " ",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, " ",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "R",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "u",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "P",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "p",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "e",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "r",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, 8'hFF, 1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "t",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, "l",   1'b1, 1'b1, 16'd2},
		'{ROW_BYTE, REG_TARGET_LETTER, "R",   1'b0, 1'b0, 16'd0},
		'{ROW_BYTE, REG_TARGET_LETTER, " ",   1'b1, 1'b1, 16'd0}
	};

	char_t              tgt_letter = '0;
	digit_t [0:2]       tgt_code = '0;
	char_t              word_first = '0;
	logic               word_open = 1'b0;
	digit_t [0:2]       word_code = '0;
	int                 code_pos = 0;
	digit_t             last_code_digit = '0;
	int unsigned        sentence_matches = 0;

	logic [MATCH_W-1:0] match_counts_due [$];
	char_t              sentence_bytes [$];
	int                 errors = 0;
	bit                 no_idle = 1'b0;
	bit                 hold_request = 1'b0;

	function automatic logic alpha_byte(input char_t c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic digit_t consonant_class(input char_t c);
		case (c)
			"b", "f", "p", "v":                     return 3'd1;
			"c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
			"d", "t":                               return 3'd3;
			"l":                                    return 3'd4;
			"m", "n":                               return 3'd5;
			"r":                                    return 3'd6;
			default:                                return 3'd0;
		endcase
	endfunction

	function automatic void close_word();
		if (word_open && word_first == tgt_letter && word_code == tgt_code &&
				sentence_matches < 32'hFFFF) begin
			sentence_matches++;
		end
		word_first = '0;
		word_open = 1'b0;
		word_code = '0;
		code_pos = 0;
		last_code_digit = '0;
	endfunction

	function automatic bit predict_match_count(input char_t c, input logic last,
			output logic [MATCH_W-1:0] count);
		digit_t d;
		count = '0;
		if (c == WORD_SEP) begin
			close_word();
		end else if (alpha_byte(c)) begin
			if (!word_open) begin
				word_first = c;
				word_open = 1'b1;
			end else if (code_pos < 3) begin
				d = consonant_class(c);
				if (d != 3'd0 && d != last_code_digit) begin
					word_code[code_pos] = d;
					code_pos++;
					last_code_digit = d;
				end
			end
		end
		if (!last) begin
			return 1'b0;
		end
		close_word();
		count = sentence_matches[MATCH_W-1:0];
		sentence_matches = 0;
		return 1'b1;
	endfunction

	function automatic void append_byte(input char_t c);
		sentence_bytes.insert(sentence_bytes.size(), c);
	endfunction

	function automatic char_t lower_letter();
		return char_t'(8'h61 + $urandom_range(25));
	endfunction

	function automatic char_t upper_letter();
		return char_t'(8'h41 + $urandom_range(25));
	endfunction

	function automatic char_t consonant_for(input digit_t d);
		string choices;
		case (d)
			3'd1:    choices = "bfpv";
			3'd2:    choices = "cgjkqsxz";
			3'd3:    choices = "dt";
			3'd4:    choices = "l";
			3'd5:    choices = "mn";
			default: choices = "r";
		endcase
		return choices[$urandom_range(choices.len() - 1)];
	endfunction

	function automatic char_t filler_byte();
		string quiet;
		quiet = "aeiouhwy";
		case ($urandom_range(3))
			0, 1:    return quiet[$urandom_range(quiet.len() - 1)];
			2:       return upper_letter();
			default: return $urandom_range(1) ? char_t'(8'h21 + $urandom_range(31))
				: char_t'(8'h80 + $urandom_range(127));
		endcase
	endfunction

	task automatic send_byte(input char_t c, input logic last, input logic typed = 1'b0,
			input logic [MATCH_W-1:0] typed_count = '0);
		logic [MATCH_W-1:0] count;
		while (!no_idle && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_match_count(c, last, count)) begin
			match_counts_due.insert(match_counts_due.size(), typed ? typed_count : count);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (match_counts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input char_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TARGET_LETTER: tgt_letter = value;
			REG_DIGIT_ONE:     tgt_code[0] = value[DIGIT_W-1:0];
			REG_DIGIT_TWO:     tgt_code[1] = value[DIGIT_W-1:0];
			REG_DIGIT_THREE:   tgt_code[2] = value[DIGIT_W-1:0];
			default: ;
		endcase
	endtask

	initial begin : result_sink
		int unsigned        stall_left;
		logic [MATCH_W-1:0] want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (match_counts_due.size() == 0) begin
					$error("match_count: no result expected, actual %0d", m_axis_tdata);
					errors++;
				end else begin
					want = match_counts_due.pop_front();
					if (m_axis_tdata !== want) begin
						$error("match_count: expected %0d, actual %0d", want, m_axis_tdata);
						errors++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 400;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin : sentence_source
		char_t        letter;
		digit_t [0:2] code;
		digit_t       prev;
		int unsigned  phase_items;
		int           words;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(script); i++) begin
			if (script[i].kind == ROW_REG) begin
				settle();
				write_reg(script[i].reg_idx, script[i].value);
			end else begin
				send_byte(script[i].value, script[i].last, script[i].typed, script[i].count);
			end
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: begin
					letter = 8'h00;
					code = '0;
				end
				1: begin
					letter = 8'hFF;
					code = {3'd7, 3'd7, 3'd7};
				end
				default: begin
					letter = $urandom_range(1) ? upper_letter() : lower_letter();
					for (int j = 0; j < 3; j++) begin
						code[j] = ($urandom_range(9) < 8) ? digit_t'($urandom_range(1, 6))
							: ($urandom_range(1) ? 3'd0 : 3'd7);
					end
				end
			endcase
			write_reg(REG_TARGET_LETTER, letter);
			for (int j = 0; j < 3; j++) begin
				write_reg(cfg_reg_t'(j + 1), char_t'({5'($urandom_range(31)), code[j]}));
			end
			no_idle = (p == 2);
			phase_items = 0;
			while (phase_items < 130) begin
				sentence_bytes.delete();
				if ($urandom_range(9) == 0) begin
					append_byte(char_t'($urandom_range(255)));
				end else begin
					words = $urandom_range(1, 6);
					for (int w = 0; w < words; w++) begin
						if (w != 0) begin
							case ($urandom_range(7))
								0: begin
									append_byte(WORD_SEP);
									append_byte(WORD_SEP);
								end
								1: begin
									append_byte(filler_byte());
									append_byte(WORD_SEP);
								end
								default: append_byte(WORD_SEP);
							endcase
						end
						if ($urandom_range(1)) begin
							// Word built to carry the target code, with ignored letters in between.
							append_byte(alpha_byte(tgt_letter) ? tgt_letter : lower_letter());
							prev = '0;
							for (int j = 0; j < 3; j++) begin
								if (tgt_code[j] == 3'd0 || tgt_code[j] == 3'd7) begin
									break;
								end
								repeat ($urandom_range(2)) append_byte(filler_byte());
								if (prev != 3'd0 && $urandom_range(3) == 0) begin
									append_byte(consonant_for(prev));
								end
								append_byte(consonant_for(tgt_code[j]));
								prev = tgt_code[j];
							end
							repeat ($urandom_range(3)) append_byte(lower_letter());
						end else begin
							repeat ($urandom_range(1, 8)) begin
								case ($urandom_range(6))
									0:       append_byte(upper_letter());
									1:       append_byte(char_t'($urandom_range(255)));
									default: append_byte(lower_letter());
								endcase
							end
						end
					end
					if ($urandom_range(4) == 0) begin
						append_byte(WORD_SEP);
					end
				end
				phase_items += sentence_bytes.size();
				foreach (sentence_bytes[k]) begin
					send_byte(sentence_bytes[k], k == sentence_bytes.size() - 1);
				end
			end
		end

		// The output side holds off while short sentences keep arriving.
		settle();
		no_idle = 1'b0;
		hold_request = 1'b1;
		repeat (60) send_byte(lower_letter(), 1'b1);
		settle();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/swmc_pkg.sv
src/soundex_word_match_counter_core.sv
src/swmc_checker.sv
test/testbench.sv
